@@ src/vfasm_pkg.sv @@
// ----------------------------------------------------------------------------
// vfasm_pkg: shared types and constants for the binary32 add/sub/mul block.
// Holds the opcode encoding and IEEE-754 field constants.
// ----------------------------------------------------------------------------
`default_nettype none
package vfasm_pkg;
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_MUL_ALT = 2'd3
  } opcode_t;

  localparam logic [31:0] QNAN = 32'h7FC00000;
  localparam logic [7:0] EXP_MAX = 8'hFF;
endpackage
`default_nettype wire

@@ src/vector_float_add_sub_mul_top.sv @@
// ----------------------------------------------------------------------------
// vector_float_add_sub_mul_top: pipelined binary32 add, subtract, multiply.
// Four register stages: unpack/align, add or multiply, normalize, round/pack.
// ----------------------------------------------------------------------------
// Each request carries two IEEE-754 binary32 operands and an opcode (add,
// subtract a minus b, or multiply; opcode 3 multiplies as well) and yields
// exactly one result, rounded to nearest even with full subnormal, infinity
// and NaN handling. Every NaN result is the canonical quiet NaN 0x7FC00000.
// The last flag travels unchanged with its element. The pipeline accepts one
// request every cycle while the output is not stalled. After the edge that
// accepts a request, its result passes through the four register stages
// (operand alignment, the 24x24 multiply or the wide add, the leading-zero
// normalize shift, and the final rounding) before out_valid rises.
// A stall on the output freezes the unbroken run of full stages behind it, but
// bubbles are squeezed out: a stage accepts new data whenever it is empty or
// the stage after it advances, so nothing is lost or repeated.
`default_nettype none
module vector_float_add_sub_mul_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  input  wire logic        in_last_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_outcome,
  output logic             out_last_out
);

  // Stage valid bits and advance enables.
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4 = !v4_r || out_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  // ---------------------------------------------------------------- stage 1
  // Unpack, resolve special operands, and align the smaller addend.
  logic        s1_mul_r, s1_spec_r, s1_last_r, s1_sign_r, s1_sub_r;
  logic [31:0] s1_spec_val_r;
  logic signed [9:0] s1_exp_r;
  logic [23:0] s1_siga_r, s1_sigb_r;
  logic [63:0] s1_mb_r;

  logic [31:0] a_c, b_c, big, sml, t_c;
  logic        nan_a, nan_b, is_mul;
  logic [7:0]  ea, eb, eam, ebm;
  logic [23:0] sa_c, sb_c;
  logic        spec_c;
  logic [31:0] spec_val_c;
  logic [8:0]  shamt;
  logic [63:0] mb_full, mb_sh;
  logic        sticky_c;
  logic signed [9:0] exp_c;
  logic        sign_c;

  always_comb begin
    is_mul = in_opcode[1];
    a_c = in_operand_a;
    b_c = (in_opcode == vfasm_pkg::OP_SUB) ? {~in_operand_b[31], in_operand_b[30:0]}
                                            : in_operand_b;
    nan_a = a_c[30:0] > 31'h7F800000;
    nan_b = b_c[30:0] > 31'h7F800000;
    if (!is_mul && a_c[30:0] < b_c[30:0]) begin
      big = b_c; sml = a_c;
    end else begin
      big = a_c; sml = b_c;
    end
    t_c = big;
    ea = big[30:23];
    eb = sml[30:23];
    sa_c = {ea != 8'd0, big[22:0]};
    sb_c = {eb != 8'd0, sml[22:0]};
    eam = (ea == 8'd0) ? 8'd1 : ea;
    ebm = (eb == 8'd0) ? 8'd1 : eb;
    spec_c = 1'b0;
    spec_val_c = 32'd0;
    sign_c = big[31];
    if (nan_a || nan_b) begin
      spec_c = 1'b1; spec_val_c = vfasm_pkg::QNAN;
    end else if (is_mul) begin
      sign_c = a_c[31] ^ b_c[31];
      if (a_c[30:23] == vfasm_pkg::EXP_MAX || b_c[30:23] == vfasm_pkg::EXP_MAX) begin
        spec_c = 1'b1;
        spec_val_c = (a_c[30:0] == 31'd0 || b_c[30:0] == 31'd0) ? vfasm_pkg::QNAN
                     : {sign_c, 31'h7F800000};
      end else if (a_c[30:0] == 31'd0 || b_c[30:0] == 31'd0) begin
        spec_c = 1'b1; spec_val_c = {sign_c, 31'd0};
      end
    end else begin
      if (ea == vfasm_pkg::EXP_MAX) begin
        spec_c = 1'b1;
        spec_val_c = (eb == vfasm_pkg::EXP_MAX && big[31] != sml[31]) ? vfasm_pkg::QNAN
                     : t_c;
      end else if ((big[30:0] | sml[30:0]) == 31'd0) begin
        spec_c = 1'b1;
        spec_val_c = (big[31] == sml[31]) ? big : 32'd0;
      end
    end
    // Alignment with sticky; the addend occupies bits 62:39.
    shamt = {1'b0, eam} - {1'b0, ebm};
    mb_full = {1'b0, sb_c, 39'd0};
    sticky_c = 1'b0;
    if (shamt >= 9'd63) begin
      mb_sh = {63'd0, mb_full != 64'd0};
    end else begin
      mb_sh = mb_full >> shamt[5:0];
      sticky_c = (mb_full & ((64'd1 << shamt[5:0]) - 64'd1)) != 64'd0;
      mb_sh[0] = mb_sh[0] | sticky_c;
    end
    if (is_mul)
      exp_c = $signed({2'b00, ea == 8'd0 ? 8'd1 : ea})
            + $signed({2'b00, eb == 8'd0 ? 8'd1 : eb}) - 10'sd127;
    else
      exp_c = $signed({2'b00, eam});
  end

  // In multiply mode big/sml are a/b in order, so sa_c/sb_c are the significands.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
    if (en1) begin
      s1_mul_r      <= is_mul;
      s1_spec_r     <= spec_c;
      s1_spec_val_r <= spec_val_c;
      s1_last_r     <= in_last_in;
      s1_sign_r     <= sign_c;
      s1_sub_r      <= big[31] != sml[31];
      s1_exp_r      <= exp_c;
      s1_siga_r     <= sa_c;
      s1_sigb_r     <= sb_c;
      s1_mb_r       <= mb_sh;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Add/subtract the aligned significands, or multiply them.
  logic        s2_spec_r, s2_last_r, s2_sign_r;
  logic [31:0] s2_spec_val_r;
  logic signed [9:0] s2_exp_r;
  logic [63:0] s2_m_r;
  logic [63:0] ma_c, m2_c;
  logic [47:0] prod_c;

  always_comb begin
    ma_c = {1'b0, s1_siga_r, 39'd0};
    prod_c = s1_siga_r * s1_sigb_r;
    if (s1_mul_r)
      m2_c = {prod_c, 16'd0};
    else if (s1_sub_r)
      m2_c = ma_c - s1_mb_r;
    else
      m2_c = ma_c + s1_mb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
    if (en2) begin
      s2_spec_r     <= s1_spec_r;
      s2_spec_val_r <= s1_spec_val_r;
      s2_last_r     <= s1_last_r;
      s2_sign_r     <= s1_sign_r;
      s2_exp_r      <= s1_exp_r;
      s2_m_r        <= m2_c;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Normalize so that bit 62 leads, then denormalize into the subnormal range.
  logic        s3_spec_r, s3_last_r, s3_sign_r, s3_zero_r;
  logic [31:0] s3_spec_val_r;
  logic signed [9:0] s3_exp_r;
  logic [63:0] s3_m_r;
  logic [5:0]  lz_c;
  logic [63:0] mn_c, md_c;
  logic signed [9:0] en_c;
  logic [9:0]  dsh;

  always_comb begin
    lz_c = 6'd0;
    for (int i = 0; i <= 62; i++) begin
      if (s2_m_r[i]) lz_c = 6'(62 - i);
    end
    if (s2_m_r[63]) begin
      mn_c = {1'b0, s2_m_r[63:2], s2_m_r[1] | s2_m_r[0]};
      en_c = s2_exp_r + 10'sd1;
    end else begin
      mn_c = s2_m_r << lz_c;
      en_c = s2_exp_r - $signed({4'd0, lz_c});
    end
    md_c = mn_c;
    if (en_c <= 10'sd0) begin
      dsh = 10'(10'sd1 - en_c);
      if (dsh >= 10'd63)
        md_c = {63'd0, mn_c != 64'd0};
      else
        md_c = (mn_c >> dsh[5:0])
             | {63'd0, (mn_c & ((64'd1 << dsh[5:0]) - 64'd1)) != 64'd0};
    end else begin
      dsh = 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
    if (en3) begin
      s3_spec_r     <= s2_spec_r;
      s3_spec_val_r <= s2_spec_val_r;
      s3_last_r     <= s2_last_r;
      s3_sign_r     <= s2_sign_r;
      s3_zero_r     <= s2_m_r == 64'd0;
      s3_exp_r      <= en_c;
      s3_m_r        <= md_c;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Round to nearest even and pack. An exact cancellation gives +0.
  logic [31:0] out_outcome_r, res_c;
  logic        out_last_r;
  logic [24:0] q_c;
  logic [38:0] r_c;
  logic        up_c;
  logic signed [9:0] ef_c;

  always_comb begin
    q_c = {1'b0, s3_m_r[62:39]};
    r_c = s3_m_r[38:0];
    up_c = r_c[38] && ((r_c[37:0] != 38'd0) || q_c[0]);
    q_c = q_c + {24'd0, up_c};
    ef_c = s3_exp_r;
    if (s3_spec_r) begin
      res_c = s3_spec_val_r;
    end else if (s3_zero_r) begin
      res_c = 32'd0;
    end else if (s3_exp_r <= 10'sd0) begin
      res_c = {s3_sign_r, 7'd0, q_c[23:0]};
    end else begin
      if (q_c[24]) begin
        q_c = q_c >> 1;
        ef_c = s3_exp_r + 10'sd1;
      end
      if (ef_c >= 10'sd255)
        res_c = {s3_sign_r, 31'h7F800000};
      else
        res_c = {s3_sign_r, ef_c[7:0], q_c[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
    if (en4) begin
      out_outcome_r <= res_c;
      out_last_r    <= s3_last_r;
    end
  end

  assign out_valid    = v4_r;
  assign out_outcome  = out_outcome_r;
  assign out_last_out = out_last_r;

  // ------------------------------------------------------------- assertions
  // A stalled result must hold its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_outcome))
    else $error("result changed while stalled");

  // The input side must be ready whenever the output stage is empty.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v4_r |-> in_ready)
    else $error("pipeline blocked with empty output stage");

  // An accepted request occupies the first stage on the next cycle.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_ready ##0 1'b1 |=> v1_r)
    else $error("accepted request lost");
endmodule
`default_nettype wire
